// ===== hw/rtl/hpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared widths, fixed-point constants, command and status types and the
// CORDIC arctangent table of the heading PID controller.
// ----------------------------------------------------------------------------
package hpc_pkg;

  // Field widths.
  localparam int POS_W  = 32;  // Q16.16 positions
  localparam int ANG_W  = 16;  // Q3.12 headings
  localparam int GAIN_W = 20;  // unsigned Q4.16 gains
  localparam int ERR_W  = 15;  // wrapped heading error on the output
  localparam int PREV_W = 16;  // stored previous error
  localparam int SUM_W  = 20;  // leaky error sum, Q7.12
  localparam int DRV_W  = 16;  // drive output

  // Datapath widths.
  localparam int DXY_W  = POS_W + 1;  // position difference
  localparam int XY_W   = 36;         // CORDIC x and y, covers the gain growth
  localparam int Z_W    = 21;         // Q16 angles including the half-plane base
  localparam int E_W    = 21;         // blended error in Q16
  localparam int MOP_W  = 21;         // multiplier operands
  localparam int PROD_W = 2 * MOP_W;  // multiplier product
  localparam int ACC_W  = 44;         // product accumulator

  localparam int HEAD_SHIFT = 20;  // car heading Q12 to Q32 of the blend
  localparam int GOAL_SHIFT = 4;   // goal heading Q12 to Q16

  // CORDIC table.
  localparam int TABLE_LEN = 24;
  localparam int ITER_W    = 5;
  localparam int ATAN_W    = 17;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 20'd983;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 20'd33;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 20'd52429;

  // Q16 constants.
  localparam logic signed [Z_W-1:0] ANG_PI      = 21'sd205887;
  localparam logic signed [Z_W-1:0] ANG_TWO_PI  = 21'sd411775;
  localparam logic signed [Z_W-1:0] ANG_HALF_PI = 21'sd102944;
  localparam logic [GAIN_W-1:0] W_BEAR = 20'd62259;  // 0.95
  localparam logic [GAIN_W-1:0] W_GOAL = 20'd3277;   // 0.05
  localparam logic [GAIN_W-1:0] W_LEAK = 20'd58982;  // 0.9

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_BEAR = 3'd1,
    MUL_GOAL = 3'd2,
    MUL_KP   = 3'd3,
    MUL_KI   = 3'd4,
    MUL_KD   = 3'd5,
    MUL_LEAK = 3'd6
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD      = 2'd0,
    ACC_LOAD_HEAD = 2'd1,
    ACC_CLEAR     = 2'd2,
    ACC_ADD       = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic              load;      // capture a control-step transaction
    logic              clear;     // zero previous error and sum
    logic              prep;      // special cases and half-plane fold
    logic              cordic;    // one vectoring iteration
    logic [ITER_W-1:0] iter;
    mul_sel_e          mul_sel;
    acc_op_e           acc_op;
    logic              round_e;   // accumulator to Q16 error
    logic              mod_step;  // one step of the 2*pi remainder
    logic              wrap;      // wrap to +-pi and round to Q12
    logic              finish;    // load result and update state
  } dp_cmd_t;

  typedef struct packed {
    logic special;   // dx or dy is zero
    logic mod_done;  // error magnitude below 2*pi
    logic out_free;  // output register can take a result
  } dp_sts_t;

  // atan(2^-i) in Q16, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 17'd51472;
      5'd1:    val = 17'd30386;
      5'd2:    val = 17'd16055;
      5'd3:    val = 17'd8150;
      5'd4:    val = 17'd4091;
      5'd5:    val = 17'd2047;
      5'd6:    val = 17'd1024;
      5'd7:    val = 17'd512;
      5'd8:    val = 17'd256;
      5'd9:    val = 17'd128;
      5'd10:   val = 17'd64;
      5'd11:   val = 17'd32;
      5'd12:   val = 17'd16;
      5'd13:   val = 17'd8;
      5'd14:   val = 17'd4;
      5'd15:   val = 17'd2;
      5'd16:   val = 17'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/hpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_ctrl
// Sequencer of the heading PID controller: steps the datapath through the
// CORDIC iterations, the blend, the angle wrap and the PID products.
// ----------------------------------------------------------------------------
module hpc_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_tvalid_i,
  input  logic             in_func_i,
  output logic             in_tready_o,
  output hpc_pkg::dp_cmd_t cmd_o,
  input  hpc_pkg::dp_sts_t sts_i
);
  import hpc_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int CNT_W  = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(NSTEPS - 1);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_PREP   = 14'b00000000000010,
    ST_CORDIC = 14'b00000000000100,
    ST_BEAR   = 14'b00000000001000,
    ST_GOAL   = 14'b00000000010000,
    ST_ADDG   = 14'b00000000100000,
    ST_ROUND  = 14'b00000001000000,
    ST_MOD    = 14'b00000010000000,
    ST_WRAP   = 14'b00000100000000,
    ST_KP     = 14'b00001000000000,
    ST_KI     = 14'b00010000000000,
    ST_KD     = 14'b00100000000000,
    ST_LEAK   = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] iter_q, iter_d;
  logic             accept;

  assign in_tready_o = (state_q == ST_IDLE);
  assign accept      = in_tvalid_i && in_tready_o;

  always_comb begin
    state_d        = state_q;
    iter_d         = iter_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.acc_op   = ACC_HOLD;
    cmd_o.iter     = ITER_W'(iter_q);
    cmd_o.load     = accept && !in_func_i;
    cmd_o.clear    = accept && in_func_i;
    unique case (state_q)
      ST_IDLE: begin
        iter_d = '0;
        if (accept && !in_func_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        iter_d     = '0;
        state_d    = sts_i.special ? ST_BEAR : ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.cordic = 1'b1;
        if (iter_q == LAST_ITER) begin
          iter_d  = '0;
          state_d = ST_BEAR;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ST_BEAR: begin
        cmd_o.mul_sel = MUL_BEAR;
        cmd_o.acc_op  = ACC_LOAD_HEAD;
        state_d       = ST_GOAL;
      end
      ST_GOAL: begin
        cmd_o.mul_sel = MUL_GOAL;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_ADDG;
      end
      ST_ADDG: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_e = 1'b1;
        state_d       = ST_MOD;
      end
      ST_MOD: begin
        // The blended error stays below two turns, so one subtraction at most.
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = ST_KP;
      end
      ST_KP: begin
        cmd_o.mul_sel = MUL_KP;
        cmd_o.acc_op  = ACC_CLEAR;
        state_d       = ST_KI;
      end
      ST_KI: begin
        cmd_o.mul_sel = MUL_KI;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_KD;
      end
      ST_KD: begin
        cmd_o.mul_sel = MUL_KD;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_LEAK;
      end
      ST_LEAK: begin
        cmd_o.mul_sel = MUL_LEAK;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule

// ===== hw/rtl/hpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_datapath
// Registers and arithmetic of the heading PID controller: CORDIC vectoring
// unit, one shared multiplier with accumulator, error wrap, PID state, gain
// registers and the output register.
// ----------------------------------------------------------------------------
module hpc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hpc_pkg::dp_cmd_t                     cmd_i,
  output hpc_pkg::dp_sts_t                     sts_o,
  input  logic                                 cfg_we_i,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [hpc_pkg::GAIN_W-1:0]           cfg_wdata_i,
  input  logic signed [hpc_pkg::POS_W-1:0]     car_x_i,
  input  logic signed [hpc_pkg::POS_W-1:0]     car_y_i,
  input  logic signed [hpc_pkg::ANG_W-1:0]     car_heading_i,
  input  logic signed [hpc_pkg::POS_W-1:0]     goal_x_i,
  input  logic signed [hpc_pkg::POS_W-1:0]     goal_y_i,
  input  logic signed [hpc_pkg::ANG_W-1:0]     goal_heading_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [hpc_pkg::DRV_W-1:0]     drive_o,
  output logic signed [hpc_pkg::ERR_W-1:0]     heading_error_o
);
  import hpc_pkg::*;

  localparam logic signed [ACC_W-1:0]   RND16_ACC  = ACC_W'(32768);
  localparam logic signed [PROD_W-1:0]  RND16_PROD = PROD_W'(32768);
  localparam logic signed [E_W-1:0]     RND4_E     = E_W'(8);
  localparam logic signed [ACC_W-1:0]   DRV_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]   DRV_MIN    = -ACC_W'(32768);
  localparam logic signed [SUM_W+1:0]   SUM_MAX    = (SUM_W+2)'(524287);
  localparam logic signed [SUM_W+1:0]   SUM_MIN    = -(SUM_W+2)'(524288);

  logic [GAIN_W-1:0]        prop_q, integ_q, deriv_q;
  logic signed [ANG_W-1:0]  ch_q, ch_d, gh_q, gh_d;
  logic signed [XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]    z_q, z_d;
  logic signed [PROD_W-1:0] mul_q, mul_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [E_W-1:0]    e_q, e_d;
  logic signed [PREV_W-1:0] err_q, err_d;
  logic signed [PREV_W-1:0] prev_q, prev_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DRV_W-1:0]  drive_q, drive_d;
  logic signed [ERR_W-1:0]  herr_q, herr_d;

  logic signed [DXY_W-1:0]  dx, dy;
  logic signed [XY_W-1:0]   xs, ys;
  logic                     y_pos;
  logic signed [Z_W-1:0]    atan_z;
  logic signed [MOP_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PREV_W:0]   derr;
  logic signed [ACC_W-1:0]  head_term, acc_rnd, acc_sh;
  logic signed [E_W-1:0]    e_wrap, e_rnd;
  logic signed [PROD_W-1:0] leak_rnd;
  logic signed [SUM_W+1:0]  sum_new;

  assign dx = DXY_W'(goal_x_i) - DXY_W'(car_x_i);
  assign dy = DXY_W'(goal_y_i) - DXY_W'(car_y_i);

  assign xs     = x_q >>> cmd_i.iter;
  assign ys     = y_q >>> cmd_i.iter;
  assign y_pos  = !y_q[XY_W-1] && (y_q != '0);
  assign atan_z = Z_W'(atan_lut(cmd_i.iter));
  assign derr   = {err_q[PREV_W-1], err_q} - {prev_q[PREV_W-1], prev_q};

  // Shared multiplier: a signed operand times a zero-extended gain.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_BEAR: begin
        mul_a = MOP_W'(z_q);
        mul_b = MOP_W'(W_BEAR);
      end
      MUL_GOAL: begin
        mul_a = {{(MOP_W-ANG_W-GOAL_SHIFT){gh_q[ANG_W-1]}}, gh_q, {GOAL_SHIFT{1'b0}}};
        mul_b = MOP_W'(W_GOAL);
      end
      MUL_KP: begin
        mul_a = {{(MOP_W-PREV_W){err_q[PREV_W-1]}}, err_q};
        mul_b = MOP_W'(prop_q);
      end
      MUL_KI: begin
        mul_a = {{(MOP_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
        mul_b = MOP_W'(integ_q);
      end
      MUL_KD: begin
        mul_a = {{(MOP_W-PREV_W-1){derr[PREV_W]}}, derr};
        mul_b = MOP_W'(deriv_q);
      end
      MUL_LEAK: begin
        mul_a = {{(MOP_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
        mul_b = MOP_W'(W_LEAK);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign head_term = {{(ACC_W-ANG_W-HEAD_SHIFT){ch_q[ANG_W-1]}}, ch_q, {HEAD_SHIFT{1'b0}}};
  assign acc_rnd   = acc_q + RND16_ACC;
  assign acc_sh    = acc_rnd >>> 16;

  // Wrap to [-pi, pi], then round Q16 to Q12.
  always_comb begin
    if (e_q > ANG_PI) begin
      e_wrap = e_q - ANG_TWO_PI;
    end else if (e_q < -ANG_PI) begin
      e_wrap = e_q + ANG_TWO_PI;
    end else begin
      e_wrap = e_q;
    end
  end
  assign e_rnd = e_wrap + RND4_E;

  assign leak_rnd = mul_q + RND16_PROD;
  assign sum_new  = leak_rnd[SUM_W+17:16] + {{(SUM_W+2-PREV_W){err_q[PREV_W-1]}}, err_q};

  always_comb begin
    ch_d        = ch_q;
    gh_d        = gh_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    acc_d       = acc_q;
    e_d         = e_q;
    err_d       = err_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    drive_d     = drive_q;
    herr_d      = herr_q;
    out_valid_d = out_valid_q;
    mul_d       = (cmd_i.mul_sel != MUL_NONE) ? prod : mul_q;

    if (cmd_i.load) begin
      ch_d = car_heading_i;
      gh_d = goal_heading_i;
      x_d  = {{(XY_W-DXY_W){dx[DXY_W-1]}}, dx};
      y_d  = {{(XY_W-DXY_W){dy[DXY_W-1]}}, dy};
    end

    if (cmd_i.prep) begin
      if (y_q == '0) begin
        z_d = x_q[XY_W-1] ? ANG_PI : '0;
      end else if (x_q == '0) begin
        z_d = y_pos ? ANG_HALF_PI : -ANG_HALF_PI;
      end else if (x_q[XY_W-1]) begin
        // Goal behind: reflect through the origin and start from +-pi.
        x_d = -x_q;
        y_d = -y_q;
        z_d = y_pos ? ANG_PI : -ANG_PI;
      end else begin
        z_d = '0;
      end
    end

    if (cmd_i.cordic) begin
      if (y_pos) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_z;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_z;
      end
    end

    case (cmd_i.acc_op)
      ACC_LOAD_HEAD: acc_d = -head_term;
      ACC_CLEAR:     acc_d = '0;
      ACC_ADD:       acc_d = acc_q + {{(ACC_W-PROD_W){mul_q[PROD_W-1]}}, mul_q};
      default:       acc_d = acc_q;
    endcase

    if (cmd_i.round_e) begin
      e_d = acc_rnd[E_W+15:16];
    end

    // Remainder that keeps the sign of the dividend.
    if (cmd_i.mod_step) begin
      if (e_q >= ANG_TWO_PI) begin
        e_d = e_q - ANG_TWO_PI;
      end else if (e_q <= -ANG_TWO_PI) begin
        e_d = e_q + ANG_TWO_PI;
      end
    end

    if (cmd_i.wrap) begin
      err_d = e_rnd[PREV_W+3:4];
    end

    if (cmd_i.finish) begin
      if (acc_sh > DRV_MAX) begin
        drive_d = DRV_W'(DRV_MAX);
      end else if (acc_sh < DRV_MIN) begin
        drive_d = DRV_W'(DRV_MIN);
      end else begin
        drive_d = acc_sh[DRV_W-1:0];
      end
      herr_d = err_q[ERR_W-1:0];
      prev_d = err_q;
      if (sum_new > SUM_MAX) begin
        sum_d = SUM_W'(SUM_MAX);
      end else if (sum_new < SUM_MIN) begin
        sum_d = SUM_W'(SUM_MIN);
      end else begin
        sum_d = sum_new[SUM_W-1:0];
      end
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.clear) begin
      prev_d = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q      <= PROP_GAIN_RST;
      integ_q     <= INTEG_GAIN_RST;
      deriv_q     <= DERIV_GAIN_RST;
      prev_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROP_GAIN:  prop_q  <= cfg_wdata_i;
          CFG_INTEG_GAIN: integ_q <= cfg_wdata_i;
          CFG_DERIV_GAIN: deriv_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    gh_q    <= gh_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    mul_q   <= mul_d;
    acc_q   <= acc_d;
    e_q     <= e_d;
    err_q   <= err_d;
    drive_q <= drive_d;
    herr_q  <= herr_d;
  end

  assign sts_o.special  = (x_q == '0) || (y_q == '0);
  assign sts_o.mod_done = (e_q < ANG_TWO_PI) && (e_q > -ANG_TWO_PI);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign heading_error_o = herr_q;

endmodule

// ===== hw/rtl/heading_pid_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_controller_unit
// Steering PID on the heading error toward a goal pose, with a leaky integral.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one pose pair per transaction. tuser selects the
//   operation: 0 runs a control step, 1 clears the stored error and sum and
//   produces no result. Each control step produces one master transaction
//   with the drive value and the wrapped heading error.
//   Gains are written through the configuration port while the block is idle;
//   index 0 is Kp, 1 is Ki*dt, 2 is Kd/dt. Writes to other indexes are dropped.
//   The time of a control step from acceptance to a valid result is set by
//   the iterative CORDIC unit and the single shared multiplier; a blended
//   error of a full turn or more needs a remainder subtraction, and a goal
//   level with the car in x or y skips the CORDIC iterations. A clear is
//   taken while idle and leaves the block idle.
//   One transaction is in work at a time; the next one is accepted in the
//   cycle after the result lands in the output register, even if it has not
//   been taken. If the receiver stalls, the result is held and the following
//   step waits in its last cycle until the output register frees up.
//   Reset restores the default gains and zeroes the error state.
// ----------------------------------------------------------------------------
module heading_pid_controller_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // car_x[31:0], car_y[63:32], car_heading[79:64], goal_x[111:80],
  // goal_y[143:112], goal_heading[159:144]
  input  logic [159:0]                  s_axis_tdata,
  // func[0]
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // drive[15:0], heading_error[30:16], zero[31]
  output logic [31:0]                   m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hpc_pkg::GAIN_W-1:0]    cfg_wdata_i
);
  import hpc_pkg::*;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic signed [DRV_W-1:0] drive;
  logic signed [ERR_W-1:0] heading_error;

  hpc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_tready_o (s_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hpc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .car_x_i         (s_axis_tdata[31:0]),
    .car_y_i         (s_axis_tdata[63:32]),
    .car_heading_i   (s_axis_tdata[79:64]),
    .goal_x_i        (s_axis_tdata[111:80]),
    .goal_y_i        (s_axis_tdata[143:112]),
    .goal_heading_i  (s_axis_tdata[159:144]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .drive_o         (drive),
    .heading_error_o (heading_error)
  );

  assign m_axis_tdata = {1'b0, heading_error, drive};

endmodule

// ===== hw/rtl/hpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_checker
// Port-level checks of the heading PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module hpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tuser,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);
  import hpc_pkg::*;

  localparam logic signed [ERR_W-1:0] HERR_MAX = 15'sd12868;
  localparam logic signed [ERR_W-1:0] HERR_MIN = -15'sd12868;

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The wrapped error never leaves [-pi, pi].
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= HERR_MAX) &&
                      ($signed(m_axis_tdata[30:16]) >= HERR_MIN))
    else $error("heading error out of range");

  // A control step keeps the block busy for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("ready after a control step was accepted");

  // A clear produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !$rose(m_axis_tvalid))
    else $error("result raised by a clear");

  // The padding bit of the result is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("result padding bit set");

endmodule

bind heading_pid_controller_unit hpc_checker u_hpc_checker (.*);

// ===== test/heading_pid_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_controller_unit_test
// Self-checking bench for the heading PID controller. A short table of
// directed poses covers the bearing quadrants, the axis and coincident cases,
// field extremes and clears. Random poses follow under several gain settings.
// Every accepted control step is run through a bit-exact steering predictor,
// and each result transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module heading_pid_controller_unit_test;

  localparam int    CLK_HALF     = 6;
  localparam int    CYCLE_LIMIT  = 600000;
  localparam int    SETTLE_TAIL  = 64;    // well past the step latency
  localparam int    IDLE_PCT     = 19;
  localparam int    HOLDOFF_LEN  = 300;
  localparam int    CORDIC_ITERS = 16;

  localparam logic [hpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // Q16 angle and weight constants of the steering law.
  localparam longint PI_Q16      = 205887;
  localparam longint TWO_PI_Q16  = 411775;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint BEAR_WEIGHT = 62259;
  localparam longint GOAL_WEIGHT = 3277;
  localparam longint SUM_LEAK    = 58982;

  localparam int      ONE_M    = 65536;
  localparam int      POS_MIN  = 32'sh8000_0000;
  localparam int      POS_MAX  = 32'sh7fff_ffff;
  localparam shortint HEAD_MIN = 16'sh8000;
  localparam shortint HEAD_MAX = 16'sh7fff;

  localparam longint ATAN_Q16 [24] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef enum bit {
    FUNC_STEP  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] car_x;
    logic signed [31:0] car_y;
    logic signed [15:0] car_heading;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
  } pose_req_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [14:0] heading_error;
  } steer_out_t;

  typedef struct packed {
    pose_req_t  req;
    logic       typed;      // take typed_out instead of the predictor's answer
    steer_out_t typed_out;
  } steer_vector_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic [159:0]                  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [31:0]                   m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [hpc_pkg::GAIN_W-1:0]    cfg_wdata_i = '0;

  // Predictor copy of the gains and the error state.
  longint kp_gain;
  longint ki_dt_gain;
  longint kd_dt_gain;
  longint last_err;
  longint err_sum;

  steer_out_t    pending_steer_q[$];
  steer_vector_t directed_rows[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  logic          no_idle = 1'b0;
  logic          holdoff_req = 1'b0;
  logic          holdoff_ack = 1'b0;
  int            holdoff_left = 0;

  heading_pid_controller_unit #(
    .CORDIC_STEPS(CORDIC_ITERS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("heading_pid_controller_unit_test NOT OK");
      $finish;
    end
  end

  // Four-quadrant bearing in Q16 radians; the left half-plane is folded
  // through the origin and rotated back by pi afterwards.
  function automatic longint goal_bearing(input longint dx, input longint dy);
    longint x;
    longint y;
    longint z;
    longint base;
    longint xs;
    longint ys;
    if (dy == 0) return (dx < 0) ? PI_Q16 : 0;
    if (dx == 0) return (dy > 0) ? HALF_PI_Q16 : -HALF_PI_Q16;
    x = dx;
    y = dy;
    z = 0;
    base = 0;
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      base = (dy > 0) ? PI_Q16 : -PI_Q16;
    end
    for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    return base + z;
  endfunction

  function automatic bit compute_steering(input pose_req_t r, output steer_out_t res);
    longint theta;
    longint blend;
    longint e16;
    longint err;
    longint acc;
    longint leaked;
    res = '0;
    if (r.func == FUNC_CLEAR) begin
      last_err = 0;
      err_sum = 0;
      return 1'b0;
    end
    theta = goal_bearing(longint'(r.goal_x) - longint'(r.car_x),
                         longint'(r.goal_y) - longint'(r.car_y));
    blend = BEAR_WEIGHT * theta + GOAL_WEIGHT * (longint'(r.goal_heading) * 16)
          - longint'(r.car_heading) * 1048576;
    e16 = (blend + 32768) >>> 16;
    e16 = e16 % TWO_PI_Q16;
    if (e16 > PI_Q16) e16 = e16 - TWO_PI_Q16;
    else if (e16 < -PI_Q16) e16 = e16 + TWO_PI_Q16;
    err = (e16 + 8) >>> 4;

    acc = kp_gain * err + ki_dt_gain * err_sum + kd_dt_gain * (err - last_err);
    acc = (acc + 32768) >>> 16;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    res.drive = acc[15:0];
    res.heading_error = err[14:0];

    last_err = err;
    leaked = ((SUM_LEAK * err_sum + 32768) >>> 16) + err;
    if (leaked > 524287) leaked = 524287;
    else if (leaked < -524288) leaked = -524288;
    err_sum = leaked;
    return 1'b1;
  endfunction

  function automatic steer_vector_t pose_row(input func_e f, input int cx, input int cy,
                                             input shortint ch, input int gx, input int gy,
                                             input shortint gh, input bit typed,
                                             input shortint drv, input shortint herr);
    steer_vector_t v;
    v.req = '{f, cx, cy, ch, gx, gy, gh};
    v.typed = typed;
    v.typed_out.drive = drv;
    v.typed_out.heading_error = herr[14:0];
    return v;
  endfunction

  function automatic steer_vector_t random_row();
    steer_vector_t v;
    int kind;
    kind = $urandom_range(99);
    v = '0;
    v.req.func = FUNC_STEP;
    v.req.car_x = $urandom;
    v.req.car_y = $urandom;
    v.req.car_heading = 16'($urandom);
    v.req.goal_heading = 16'($urandom);
    v.req.goal_x = $urandom;
    v.req.goal_y = $urandom;
    if (kind < 6) begin
      v.req.func = FUNC_CLEAR;
    end else if (kind < 40) begin
      v.req.goal_x = v.req.car_x + (int'($urandom_range(2097152)) - 1048576);
      v.req.goal_y = v.req.car_y + (int'($urandom_range(2097152)) - 1048576);
    end else if (kind < 48) begin
      v.req.goal_x = v.req.car_x + (int'($urandom_range(32)) - 16);
      v.req.goal_y = v.req.car_y + (int'($urandom_range(32)) - 16);
    end else if (kind < 56) begin
      v.req.goal_x = v.req.car_x;
    end else if (kind < 64) begin
      v.req.goal_y = v.req.car_y;
    end else if (kind < 67) begin
      v.req.goal_x = v.req.car_x;
      v.req.goal_y = v.req.car_y;
    end else if (kind < 80) begin
      // Headings near each other: the goal heading lies within 0.25 rad of the car's.
      v.req.goal_heading = v.req.car_heading + 16'(int'($urandom_range(2048)) - 1024);
    end
    return v;
  endfunction

  task automatic push_item(input steer_vector_t row);
    steer_out_t predicted;
    bit         has_result;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.req.func;
    s_axis_tdata <= {row.req.goal_heading, row.req.goal_y, row.req.goal_x,
                     row.req.car_heading, row.req.car_y, row.req.car_x};
    do @(posedge clk_i); while (!s_axis_tready);
    has_result = compute_steering(row.req, predicted);
    if (has_result) pending_steer_q.push_back(row.typed ? row.typed_out : predicted);
  endtask

  task automatic wait_results();
    while (pending_steer_q.size() != 0) @(posedge clk_i);
  endtask

  // A clear leaves nothing to wait for, so a fixed tail follows the last result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait_results();
    repeat (SETTLE_TAIL) @(posedge clk_i);
  endtask

  task automatic write_gains(input logic [19:0] kp, input logic [19:0] ki,
                             input logic [19:0] kd, input logic [19:0] spare);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= hpc_pkg::CFG_PROP_GAIN;
    cfg_wdata_i <= kp;
    @(posedge clk_i);
    cfg_idx_i <= hpc_pkg::CFG_INTEG_GAIN;
    cfg_wdata_i <= ki;
    @(posedge clk_i);
    cfg_idx_i <= hpc_pkg::CFG_DERIV_GAIN;
    cfg_wdata_i <= kd;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SPARE_IDX;
    cfg_wdata_i <= spare;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    kp_gain = kp;
    ki_dt_gain = ki;
    kd_dt_gain = kd;
  endtask

  task automatic random_burst(input int count, input int holdoff_at, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == holdoff_at) holdoff_req <= ~holdoff_req;
      if (k == pause_at) begin
        s_axis_tvalid <= 1'b0;
        wait_results();
        @(posedge clk_i);
      end
      push_item(random_row());
    end
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      m_axis_tready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req != holdoff_ack) begin
      m_axis_tready <= 1'b0;
      holdoff_ack <= holdoff_req;
      holdoff_left <= HOLDOFF_LEN;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    steer_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_steer_q.size() == 0) begin
        $error("result transaction with no prediction waiting: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_steer_q.pop_front();
        if (m_axis_tdata[15:0] !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive,
                 $signed(m_axis_tdata[15:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[30:16] !== want.heading_error) begin
          $error("heading_error: expected %0d, actual %0d", want.heading_error,
                 $signed(m_axis_tdata[30:16]));
          mismatch_count++;
        end
        if (m_axis_tdata[31] !== 1'b0) begin
          $error("pad: expected 0, actual %b", m_axis_tdata[31]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    kp_gain = hpc_pkg::PROP_GAIN_RST;
    ki_dt_gain = hpc_pkg::INTEG_GAIN_RST;
    kd_dt_gain = hpc_pkg::DERIV_GAIN_RST;
    last_err = 0;
    err_sum = 0;

    directed_rows = '{
      // Zero rows: bearing 0 or car on goal, headings 0, state at zero.
      pose_row(FUNC_STEP, 0, 0, 0, ONE_M, 0, 0, 1, 0, 0),
      pose_row(FUNC_STEP, POS_MIN, POS_MIN, 0, POS_MIN, POS_MIN, 0, 1, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, -ONE_M, 0, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, 0, ONE_M, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, 0, -ONE_M, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, -ONE_M, ONE_M, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, -ONE_M, -ONE_M, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, 3 * ONE_M, ONE_M, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, ONE_M, -5 * ONE_M, 0, 0, 0, 0),
      pose_row(FUNC_STEP, POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX, 0, 0, 0, 0),
      pose_row(FUNC_STEP, POS_MAX, POS_MIN, HEAD_MAX, POS_MIN, POS_MAX, HEAD_MIN, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, HEAD_MIN, ONE_M, 0, HEAD_MAX, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, HEAD_MAX, -ONE_M, 0, HEAD_MIN, 0, 0, 0),
      pose_row(FUNC_STEP, POS_MAX, POS_MAX, HEAD_MAX, POS_MIN, POS_MAX, HEAD_MAX, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, 1, 1, 0, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, -1, 0, 0, 0, 0, 0),
      pose_row(FUNC_CLEAR, -1, -1, -1, -1, -1, -1, 0, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, ONE_M, 0, 0, 1, 0, 0),
      pose_row(FUNC_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0),
      pose_row(FUNC_STEP, 0, 0, HEAD_MIN, 0, -ONE_M, HEAD_MIN, 0, 0, 0),
      pose_row(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      pose_row(FUNC_CLEAR, POS_MAX, POS_MIN, HEAD_MAX, POS_MIN, POS_MAX, HEAD_MIN, 0, 0, 0),
      pose_row(FUNC_STEP, ONE_M, ONE_M, HEAD_MAX, 0, 2 * ONE_M, HEAD_MAX, 0, 0, 0)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) push_item(directed_rows[i]);
    random_burst(130, -1, -1);

    // All gains at full scale; the drive saturates, and one long hold-off
    // on the result side backs the block up into its input.
    write_gains(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'($urandom));
    random_burst(125, 40, -1);

    write_gains(20'h00000, 20'h00000, 20'h00000, 20'($urandom));
    random_burst(125, -1, -1);

    no_idle <= 1'b1;
    write_gains(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
    random_burst(125, -1, -1);
    no_idle <= 1'b0;

    write_gains(20'hFFFFF, 20'h00000, 20'h00000, 20'($urandom));
    random_burst(125, -1, 60);

    write_gains(20'h00000, 20'hFFFFF, 20'h00000, 20'($urandom));
    random_burst(125, -1, -1);

    write_gains(hpc_pkg::PROP_GAIN_RST, hpc_pkg::INTEG_GAIN_RST,
                hpc_pkg::DERIV_GAIN_RST, 20'($urandom));
    random_burst(125, -1, -1);

    drain();
    if (mismatch_count == 0) begin
      $display("heading_pid_controller_unit_test OK");
    end else begin
      $display("heading_pid_controller_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hpc_pkg.sv
hw/rtl/hpc_ctrl.sv
hw/rtl/hpc_datapath.sv
hw/rtl/heading_pid_controller_unit.sv
hw/rtl/hpc_checker.sv
test/heading_pid_controller_unit_test.sv
